### sv/sohash_pkg.sv
// shared types, constants and mixing functions of the seeded one-at-a-time hash
// no dependencies; used by every module of the block

package sohash_pkg;

  localparam int unsigned HashW = 32;
  localparam int unsigned ByteW = 8;

  // longest key that is mixed byte by byte
  localparam logic [ByteW-1:0] KeyLenMax = 8'd16;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgSeedLow  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSeedHigh = 1'b1;

  // queue between front and back, and result queue (powers of two)
  localparam int unsigned JobDepth = 4;
  localparam int unsigned JobPtrW  = $clog2(JobDepth);
  localparam int unsigned JobCntW  = $clog2(JobDepth + 1);
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = $clog2(ResDepth);
  localparam int unsigned ResCntW  = $clog2(ResDepth + 1);

  // finalization pipeline: four seed byte rounds, then three avalanche steps
  localparam int unsigned FinStages = 7;
  localparam int unsigned FinIdxW   = $clog2(FinStages);
  localparam logic [FinIdxW-1:0] FinShift6  = 3'd4;
  localparam logic [FinIdxW-1:0] FinShift11 = 3'd5;
  localparam logic [FinIdxW-1:0] FinShift15 = 3'd6;

  typedef struct packed {
    logic [HashW-1:0] hash;
    logic             short_key;  // key_length at most KeyLenMax
  } job_t;

  function automatic logic [HashW-1:0] mix_byte(input logic [HashW-1:0] h,
                                                input logic [ByteW-1:0] b);
    logic [HashW-1:0] t;
    t = h + (h << 10);
    t = t ^ (t >> 6);
    return t + {{(HashW-ByteW){1'b0}}, b};
  endfunction

  // one step of the finalization; long keys only take the last step
  function automatic logic [HashW-1:0] fin_step(input logic [FinIdxW-1:0] idx,
                                                input logic [HashW-1:0]   h,
                                                input logic [HashW-1:0]   seed_hi,
                                                input logic               short_key);
    logic [HashW-1:0] t;
    t = h;
    case (idx)
      FinShift6: begin
        if (short_key) begin
          t = h + (h << 10);
          t = t ^ (t >> 6);
        end
      end
      FinShift11: begin
        if (short_key) begin
          t = h + (h << 3);
          t = t ^ (t >> 11);
        end
      end
      FinShift15: begin
        t = h + (h << 15);
      end
      default: begin
        if (short_key) begin
          t = mix_byte(h, seed_hi[ByteW*idx +: ByteW]);
        end
      end
    endcase
    return t;
  endfunction

endpackage

### sv/sohash_front.sv
// front end: takes key bytes, keeps the running hash and hands finished keys on
// depends on sohash_pkg

module sohash_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  input  logic                           full,
  input  logic [sohash_pkg::ByteW-1:0]   data_byte_i,
  input  logic [sohash_pkg::ByteW-1:0]   key_length_i,
  input  logic                           last_item_i,
  input  logic [sohash_pkg::HashW-1:0]   seed_low_i,
  output logic                           job_push_o,
  output sohash_pkg::job_t               job_o
);

  logic                         in_key_q, in_key_d;
  logic [sohash_pkg::HashW-1:0] hash_q, hash_d;
  logic [sohash_pkg::HashW-1:0] hash_base;
  logic [sohash_pkg::HashW-1:0] hash_mixed;
  logic                         short_key;
  logic                         mix_en;
  logic                         accept;

  assign accept    = push && !full;
  assign short_key = (key_length_i <= sohash_pkg::KeyLenMax);
  assign mix_en    = short_key && (key_length_i != '0);

  // a new key starts from the low seed word plus its length
  assign hash_base = in_key_q ? hash_q
                   : seed_low_i + {{(sohash_pkg::HashW-sohash_pkg::ByteW){1'b0}}, key_length_i};
  assign hash_mixed = mix_en ? sohash_pkg::mix_byte(hash_base, data_byte_i) : hash_base;

  always_comb begin
    in_key_d = in_key_q;
    hash_d   = hash_q;
    if (accept) begin
      if (last_item_i) begin
        in_key_d = 1'b0;
        hash_d   = '0;
      end else begin
        in_key_d = 1'b1;
        hash_d   = hash_mixed;
      end
    end
  end

  assign job_push_o      = accept && last_item_i;
  assign job_o.hash      = hash_mixed;
  assign job_o.short_key = short_key;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_key_q <= 1'b0;
      hash_q   <= '0;
    end else begin
      in_key_q <= in_key_d;
      hash_q   <= hash_d;
    end
  end

`ifndef SYNTHESIS
  a_last_ends_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_item_i) |=> (!in_key_q && hash_q == '0))
    else $error("key still open after its last transaction");
`endif

endmodule

### sv/sohash_jobq.sv
// short queue of finished keys between the front end and the finalization
// depends on sohash_pkg

module sohash_jobq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  sohash_pkg::job_t wr_job_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output sohash_pkg::job_t rd_job_o,
  output logic             empty_o
);

  sohash_pkg::job_t                 mem_q [sohash_pkg::JobDepth];
  logic [sohash_pkg::JobPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [sohash_pkg::JobCntW-1:0]   count_q, count_d;
  logic                             do_wr, do_rd;

  assign full_o   = (count_q == sohash_pkg::JobCntW'(sohash_pkg::JobDepth));
  assign empty_o  = (count_q == '0);
  assign do_wr    = wr_en_i && !full_o;
  assign do_rd    = rd_en_i && !empty_o;
  assign rd_job_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

`ifndef SYNTHESIS
  a_jobq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sohash_pkg::JobCntW'(sohash_pkg::JobDepth))
    else $error("job queue overflow");
`endif

endmodule

### sv/sohash_back.sv
// back end: pipelined seed mixing and avalanche, then the result queue
// depends on sohash_pkg

module sohash_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_empty_i,
  input  sohash_pkg::job_t             job_i,
  output logic                         job_pop_o,
  input  logic [sohash_pkg::HashW-1:0] seed_high_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [sohash_pkg::HashW-1:0] hash_value_o
);

  localparam int unsigned N = sohash_pkg::FinStages;

  logic [N-1:0]                 v_q;
  logic [sohash_pkg::HashW-1:0] h_q [N];
  logic [N-1:0]                 s_q;
  logic [N:0]                   rdy;

  logic [sohash_pkg::HashW-1:0] res_q [sohash_pkg::ResDepth];
  logic [sohash_pkg::ResPtrW-1:0] res_wr_q, res_rd_q;
  logic [sohash_pkg::ResCntW-1:0] res_cnt_q, res_cnt_d;
  logic                           res_full, res_wr, res_rd;

  assign res_full = (res_cnt_q == sohash_pkg::ResCntW'(sohash_pkg::ResDepth));
  assign empty    = (res_cnt_q == '0);
  assign res_wr   = v_q[N-1] && !res_full;
  assign res_rd   = pop && !empty;

  // a stage moves on when it is empty or the one after it moves on
  always_comb begin
    rdy[N] = !res_full;
    for (int i = N - 1; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end

  assign job_pop_o = !job_empty_i && rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= !job_empty_i;
      end
      for (int i = 1; i < N; i++) begin
        if (rdy[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      h_q[0] <= sohash_pkg::fin_step('0, job_i.hash, seed_high_i, job_i.short_key);
      s_q[0] <= job_i.short_key;
    end
    for (int i = 1; i < N; i++) begin
      if (rdy[i]) begin
        h_q[i] <= sohash_pkg::fin_step(sohash_pkg::FinIdxW'(i), h_q[i-1], seed_high_i,
                                       s_q[i-1]);
        s_q[i] <= s_q[i-1];
      end
    end
  end

  // result queue
  always_comb begin
    res_cnt_d = res_cnt_q;
    if (res_wr && !res_rd) begin
      res_cnt_d = res_cnt_q + 1'b1;
    end else if (res_rd && !res_wr) begin
      res_cnt_d = res_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= '0;
      res_rd_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      res_cnt_q <= res_cnt_d;
      if (res_wr) begin
        res_wr_q <= res_wr_q + 1'b1;
      end
      if (res_rd) begin
        res_rd_q <= res_rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_wr) begin
      res_q[res_wr_q] <= h_q[N-1];
    end
  end

  assign hash_value_o = res_q[res_rd_q];

`ifndef SYNTHESIS
  a_tail_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[N-1] && res_full) |=> (v_q[N-1] && $stable(h_q[N-1])))
    else $error("finished hash dropped while result queue full");
  a_res_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q <= sohash_pkg::ResCntW'(sohash_pkg::ResDepth))
    else $error("result queue overflow");
`endif

endmodule

### sv/seeded_one_at_a_time_hash.sv
// Seeded one-at-a-time hash for keys of 0 to 16 bytes. Send a key one byte per
// transaction, highest byte index first, with the total length on every byte and
// last_item_i set on the final one; an empty or over-long key is one transaction
// whose byte is ignored. One hash comes out per key. The block takes one byte
// every cycle while full is low: the running-hash round in the front end is a
// combinational loop through one register. A finished key passes a four-entry
// queue into a seven-stage finalization pipeline (seed bytes and avalanche) and
// a four-entry result queue, read at hash_value_o. full stays high only while
// the key queue is full. Write the seed registers while idle.

module seeded_one_at_a_time_hash (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sohash_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sohash_pkg::HashW-1:0]     cfg_wdata_i,
  input  logic                             push,
  output logic                             full,
  input  logic [sohash_pkg::ByteW-1:0]     data_byte_i,
  input  logic [sohash_pkg::ByteW-1:0]     key_length_i,
  input  logic                             last_item_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [sohash_pkg::HashW-1:0]     hash_value_o
);

  logic [sohash_pkg::HashW-1:0] seed_low_q, seed_high_q;
  logic                         job_push, job_pop, job_empty;
  sohash_pkg::job_t             job_wr, job_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_low_q  <= '0;
      seed_high_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sohash_pkg::CfgSeedLow:  seed_low_q  <= cfg_wdata_i;
        sohash_pkg::CfgSeedHigh: seed_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  sohash_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .data_byte_i  (data_byte_i),
    .key_length_i (key_length_i),
    .last_item_i  (last_item_i),
    .seed_low_i   (seed_low_q),
    .job_push_o   (job_push),
    .job_o        (job_wr)
  );

  sohash_jobq u_jobq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (job_push),
    .wr_job_i (job_wr),
    .full_o   (full),
    .rd_en_i  (job_pop),
    .rd_job_o (job_rd),
    .empty_o  (job_empty)
  );

  sohash_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_empty_i  (job_empty),
    .job_i        (job_rd),
    .job_pop_o    (job_pop),
    .seed_high_i  (seed_high_q),
    .empty        (empty),
    .pop          (pop),
    .hash_value_o (hash_value_o)
  );

endmodule

### tb/tb_seeded_one_at_a_time_hash.sv
// self-checking testbench for seeded_one_at_a_time_hash: key bytes are pushed from a queue,
// hashes are predicted per accepted byte and compared at every pop
// depends on sohash_pkg and the seeded_one_at_a_time_hash rtl
`timescale 1ns / 1ps

module tb_seeded_one_at_a_time_hash;

  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 24;
  localparam int HoldCycles   = 120;

  typedef struct packed {
    logic [sohash_pkg::ByteW-1:0] key_byte;
    logic [sohash_pkg::ByteW-1:0] key_len;
    logic                         is_last;
  } key_beat_t;

  logic                           clk_i        = 1'b0;
  logic                           rst_ni       = 1'b0;
  logic                           cfg_we_i     = 1'b0;
  logic [sohash_pkg::CfgIdxW-1:0] cfg_idx_i    = sohash_pkg::CfgSeedLow;
  logic [sohash_pkg::HashW-1:0]   cfg_wdata_i  = '0;
  logic                           push         = 1'b0;
  logic                           full;
  logic [sohash_pkg::ByteW-1:0]   data_byte_i  = '0;
  logic [sohash_pkg::ByteW-1:0]   key_length_i = '0;
  logic                           last_item_i  = 1'b0;
  logic                           empty;
  logic                           pop          = 1'b0;
  logic [sohash_pkg::HashW-1:0]   hash_value_o;

  key_beat_t                    pending_beats[$];
  logic [sohash_pkg::HashW-1:0] expected_hashes[$];

  // predictor state, mirrors the block
  logic [sohash_pkg::HashW-1:0] seed_low_model  = '0;
  logic [sohash_pkg::HashW-1:0] seed_high_model = '0;
  logic [sohash_pkg::HashW-1:0] run_hash        = '0;
  logic                         key_open        = 1'b0;

  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  seeded_one_at_a_time_hash dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .data_byte_i  (data_byte_i),
    .key_length_i (key_length_i),
    .last_item_i  (last_item_i),
    .empty        (empty),
    .pop          (pop),
    .hash_value_o (hash_value_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [sohash_pkg::HashW-1:0] fold_byte(
      input logic [sohash_pkg::HashW-1:0] h,
      input logic [sohash_pkg::ByteW-1:0] b);
    logic [sohash_pkg::HashW-1:0] t;
    t = h + (h << 10);
    t = t ^ (t >> 6);
    return t + sohash_pkg::HashW'(b);
  endfunction

  // advance the running hash by one accepted transaction, queue the hash on a last byte
  task automatic hash_track(input logic [sohash_pkg::ByteW-1:0] kb,
                            input logic [sohash_pkg::ByteW-1:0] kl,
                            input logic il);
    logic [sohash_pkg::HashW-1:0] h;
    int i;
    if (!key_open) begin
      run_hash = seed_low_model + sohash_pkg::HashW'(kl);
      key_open = 1'b1;
    end
    if (kl >= 1 && kl <= sohash_pkg::KeyLenMax) run_hash = fold_byte(run_hash, kb);
    if (il) begin
      h = run_hash;
      if (kl <= sohash_pkg::KeyLenMax) begin
        for (i = 0; i < 4; i++) h = fold_byte(h, seed_high_model[8*i +: 8]);
        h = h + (h << 10);
        h = h ^ (h >> 6);
        h = h + (h << 3);
        h = h ^ (h >> 11);
      end
      h = h + (h << 15);
      expected_hashes.push_back(h);
      run_hash = '0;
      key_open = 1'b0;
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [sohash_pkg::HashW-1:0] want,
                               input logic [sohash_pkg::HashW-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %0d (%s): expected %08h actual %08h", mismatch_count, what, want, got);
  endtask

  // driver: holds a byte on the ports until it is taken
  always @(posedge clk_i) begin : driver
    key_beat_t nxt;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) hash_track(data_byte_i, key_length_i, last_item_i);
      if (!push || !full) begin
        if (pending_beats.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          nxt = pending_beats.pop_front();
          push         <= 1'b1;
          data_byte_i  <= nxt.key_byte;
          key_length_i <= nxt.key_len;
          last_item_i  <= nxt.is_last;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each popped hash and paces pop
  always @(posedge clk_i) begin : monitor
    logic [sohash_pkg::HashW-1:0] want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_hashes.size() == 0) begin
          flag_mismatch("unexpected hash", 'x, hash_value_o);
        end else begin
          want = expected_hashes.pop_front();
          if (hash_value_o !== want) flag_mismatch("hash_value", want, hash_value_o);
        end
      end
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  task automatic write_seed(input logic [sohash_pkg::CfgIdxW-1:0] idx,
                            input logic [sohash_pkg::HashW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == sohash_pkg::CfgSeedLow) seed_low_model = value;
    else seed_high_model = value;
    @(negedge clk_i);
  endtask

  task automatic add_beat(input logic [sohash_pkg::ByteW-1:0] kb,
                          input logic [sohash_pkg::ByteW-1:0] kl,
                          input logic il);
    key_beat_t b;
    b.key_byte = kb;
    b.key_len  = kl;
    b.is_last  = il;
    pending_beats.push_back(b);
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || push || expected_hashes.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // single-transaction keys (empty or over-long) that each give a hash, to fill the block while pop is held off
  task automatic add_burst();
    int k;
    for (k = 0; k < 12; k++) begin
      if (k % 2 == 0) add_beat(sohash_pkg::ByteW'($urandom), 8'd0, 1'b1);
      else add_beat(sohash_pkg::ByteW'($urandom),
                    sohash_pkg::ByteW'($urandom_range(255, 17)), 1'b1);
    end
  endtask

  task automatic add_random_keys(input int n_beats);
    int added, kind, len, k;
    added = 0;
    while (added < n_beats) begin
      kind = $urandom_range(99, 0);
      if (kind < 78) begin
        len = $urandom_range(16, 1);
        for (k = 0; k < len; k++)
          add_beat(sohash_pkg::ByteW'($urandom), sohash_pkg::ByteW'(len), k == len - 1);
        added += len;
      end else if (kind < 85) begin
        add_beat(sohash_pkg::ByteW'($urandom), 8'd0, 1'b1);
        added++;
      end else if (kind < 92) begin
        add_beat(sohash_pkg::ByteW'($urandom),
                 sohash_pkg::ByteW'($urandom_range(255, 17)), 1'b1);
        added++;
      end else begin
        // malformed key: lengths change per byte, last may come early
        len = $urandom_range(5, 1);
        for (k = 0; k < len; k++)
          add_beat(sohash_pkg::ByteW'($urandom), sohash_pkg::ByteW'($urandom_range(24, 0)),
                   (k == len - 1) ? 1'b1 : logic'($urandom_range(3, 0) == 0));
        added += len;
      end
    end
  endtask

  initial begin : stimulus
    int k;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 25;
    recv_idle_pct = 65;
    write_seed(sohash_pkg::CfgSeedLow, '0);
    write_seed(sohash_pkg::CfgSeedHigh, '0);
    add_beat(8'hFF, 8'd0, 1'b1);    // empty key
    add_beat(8'h00, 8'd17, 1'b1);   // shortest long key
    add_beat(8'hFF, 8'd255, 1'b1);
    add_beat(8'h00, 8'd1, 1'b1);
    for (k = 0; k < 16; k++) add_beat(8'hFF, 8'd16, k == 15);
    add_beat(8'hA5, 8'd3, 1'b0);    // length turns long on the last byte
    add_beat(8'h5A, 8'd200, 1'b1);
    add_beat(8'h33, 8'd0, 1'b0);    // key opened by an empty-length byte
    add_beat(8'h80, 8'd2, 1'b1);
    wait_drained();

    write_seed(sohash_pkg::CfgSeedLow, '1);
    write_seed(sohash_pkg::CfgSeedHigh, '1);
    hold_requests++;
    add_burst();
    add_random_keys(140);
    wait_drained();

    send_idle_pct = 65;
    recv_idle_pct = 25;
    write_seed(sohash_pkg::CfgSeedLow, $urandom);
    write_seed(sohash_pkg::CfgSeedHigh, $urandom);
    add_random_keys(70);
    wait_drained();
    add_random_keys(70);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_seed(sohash_pkg::CfgSeedHigh, $urandom);
    write_seed(sohash_pkg::CfgSeedLow, $urandom);
    hold_requests++;
    add_burst();
    add_random_keys(140);
    wait_drained();

    if (mismatch_count == 0 && expected_hashes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
sv/sohash_pkg.sv
sv/sohash_front.sv
sv/sohash_jobq.sv
sv/sohash_back.sv
sv/seeded_one_at_a_time_hash.sv
tb/tb_seeded_one_at_a_time_hash.sv
